// ===== design/irt_pkg.sv =====
// Types, codes and the overlap test shared by the interval reservation table.
// No dependencies; used by irt_cell, irt_chain and interval_reservation_table.
package irt_pkg;

    localparam int TW  = 40;
    localparam int IDW = 24;
    localparam int CHW = 2;
    localparam int OPW = 3;
    localparam int STW = 3;

    localparam logic [OPW-1:0] OP_INSERT = 3'd0;
    localparam logic [OPW-1:0] OP_REMOVE = 3'd1;
    localparam logic [OPW-1:0] OP_DELETE = 3'd2;
    localparam logic [OPW-1:0] OP_SET_ONG = 3'd3;
    localparam logic [OPW-1:0] OP_CLR_ONG = 3'd4;

    localparam logic [STW-1:0] ST_OK      = 3'd0;
    localparam logic [STW-1:0] ST_COLLIDE = 3'd1;
    localparam logic [STW-1:0] ST_FULL    = 3'd2;
    localparam logic [STW-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STW-1:0] ST_NOID    = 3'd4;

    localparam logic [IDW-1:0] ID_MAX = 24'hFFFFFF;
    localparam logic [IDW-1:0] ID_FIRST = 24'd1;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic [CHW-1:0] channel_index;
        logic [TW-1:0]  start_time;
        logic [TW-1:0]  end_time;
        logic [IDW-1:0] target_id;
    } in_t;

    typedef struct packed {
        logic [STW-1:0] status;
        logic [IDW-1:0] entry_id;
        logic [TW-1:0]  entry_start;
        logic [TW-1:0]  entry_end;
        logic [CHW-1:0] entry_channel;
    } out_t;

    typedef struct packed {
        logic [TW-1:0]  t_start;
        logic [TW-1:0]  t_end;
        logic [IDW-1:0] id;
    } slot_t;

    // broadcast to every cell
    typedef struct packed {
        logic           load;
        logic           scan;
        logic [OPW-1:0] op;
        slot_t          item;
        logic [IDW-1:0] tid;
    } cell_cmd_t;

    // per-channel shift strobes
    typedef struct packed {
        logic ins;
        logic del;
    } shift_t;

    function automatic logic touches(input logic [TW-1:0] s, input logic [TW-1:0] e,
                                     input logic [TW-1:0] os, input logic [TW-1:0] oe);
        logic r;
        r = ((s >= os) && (s <= oe)) || ((e >= os) && (e <= oe)) || ((s < os) && (e > oe));
        return r;
    endfunction

endpackage

// ===== design/interval_reservation_table.sv =====
// Top level of the interval reservation table: command sequencer, per-channel
// chains, ongoing intervals, id counter and output register. Uses irt_pkg, irt_chain.
//
// Usage:
//   in_valid/in_ready/in_data carry one command word (op, channel, interval,
//   target id); out_valid/out_ready/out_data return exactly one result word
//   per command (status, id, interval, channel).
//   Each channel keeps its intervals in a chain of ENTRIES cells sorted by
//   start. A command is flagged in every cell at once, then the first-hit
//   flag and its payload ripple down the chain one cell per cycle; then the
//   chain shifts and the result word is registered.
//   One command is in flight at a time; in_ready returns the cycle after the
//   result word is taken, so a new command waits until the last is answered.
//   Reset empties all channels, clears ongoing intervals and restarts ids at 1.
//   A stalled receiver holds the result word and keeps in_ready low.
module interval_reservation_table #(
    parameter int CHANNELS = 4,
    parameter int ENTRIES  = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  irt_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output irt_pkg::out_t   out_data
);
    import irt_pkg::*;

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CNT_W  = $clog2(ENTRIES);
    localparam int CSW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ENTRIES);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    in_t               cmd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FILL_W-1:0] fill_reg [CHANNELS];
    logic              ong_valid_reg [CHANNELS];
    logic [TW-1:0]     ong_start_reg [CHANNELS];
    logic [TW-1:0]     ong_end_reg   [CHANNELS];
    logic [IDW-1:0]    next_id_reg;
    logic              out_valid_reg;
    out_t              out_reg;

    cell_cmd_t         ccmd;
    shift_t            shift_v [CHANNELS];
    logic              any_hit [CHANNELS];
    slot_t             hit_slot [CHANNELS];

    logic [CSW-1:0]    ch_sel;
    logic              ch_ok;
    logic              do_ins;
    logic              do_del;
    logic [CSW-1:0]    del_ch;
    logic              found;
    out_t              res;

    assign ch_sel = CSW'(cmd_reg.channel_index);
    assign ch_ok  = int'(cmd_reg.channel_index) < CHANNELS;

    assign ccmd.load         = (state_reg == S_LOAD);
    assign ccmd.scan         = (state_reg == S_SCAN);
    assign ccmd.op           = cmd_reg.op;
    assign ccmd.item.t_start = cmd_reg.start_time;
    assign ccmd.item.t_end   = cmd_reg.end_time;
    assign ccmd.item.id      = next_id_reg;
    assign ccmd.tid          = cmd_reg.target_id;

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++)
        begin : g_chan
            assign shift_v[c].ins = do_ins && (ch_sel == CSW'(c));
            assign shift_v[c].del = do_del && (del_ch == CSW'(c));

            irt_chain #(
                .ENTRIES(ENTRIES),
                .FILL_W (FILL_W)
            ) u_chain (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (ccmd),
                .shift   (shift_v[c]),
                .fill    (fill_reg[c]),
                .any_hit (any_hit[c]),
                .hit_slot(hit_slot[c])
            );
        end
    endgenerate

    // decide the command once the chains have settled
    always_comb
    begin
        res    = '0;
        do_ins = 1'b0;
        do_del = 1'b0;
        del_ch = ch_sel;
        found  = 1'b0;
        if (cmd_reg.op == OP_DELETE)
        begin
            for (int k = CHANNELS - 1; k >= 0; k--)
            begin
                if (any_hit[k])
                begin
                    found  = 1'b1;
                    del_ch = CSW'(k);
                end
            end
        end
        else
        begin
            found = ch_ok && any_hit[ch_sel];
        end
        case (cmd_reg.op)
            OP_INSERT:
            begin
                if (!ch_ok)
                    res.status = ST_FULL;
                else if (any_hit[ch_sel] ||
                         (ong_valid_reg[ch_sel] &&
                          touches(cmd_reg.start_time, cmd_reg.end_time,
                                  ong_start_reg[ch_sel], ong_end_reg[ch_sel])))
                    res.status = ST_COLLIDE;
                else if (fill_reg[ch_sel] >= FILL_MAX)
                    res.status = ST_FULL;
                else
                begin
                    do_ins            = state_reg == S_APPLY;
                    res.entry_id      = next_id_reg;
                    res.entry_start   = cmd_reg.start_time;
                    res.entry_end     = cmd_reg.end_time;
                    res.entry_channel = cmd_reg.channel_index;
                end
            end
            OP_REMOVE, OP_DELETE:
            begin
                if (!found)
                    res.status = (cmd_reg.op == OP_REMOVE) ? ST_EMPTY : ST_NOID;
                else
                begin
                    do_del            = state_reg == S_APPLY;
                    res.entry_id      = hit_slot[del_ch].id;
                    res.entry_start   = hit_slot[del_ch].t_start;
                    res.entry_end     = hit_slot[del_ch].t_end;
                    res.entry_channel = CHW'(del_ch);
                end
            end
            default: res = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_LOAD;
            S_LOAD:  state_next = S_SCAN;
            S_SCAN:  if (cnt_reg == CNT_LAST) state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            next_id_reg   <= ID_FIRST;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                fill_reg[k]      <= '0;
                ong_valid_reg[k] <= 1'b0;
                ong_start_reg[k] <= '0;
                ong_end_reg[k]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCAN)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (state_reg == S_APPLY)
            begin
                out_valid_reg <= 1'b1;
                if (do_ins)
                begin
                    fill_reg[ch_sel] <= fill_reg[ch_sel] + 1'b1;
                    next_id_reg <= (next_id_reg == ID_MAX) ? ID_FIRST : next_id_reg + 1'b1;
                end
                if (do_del)
                    fill_reg[del_ch] <= fill_reg[del_ch] - 1'b1;
                if (ch_ok && (cmd_reg.op == OP_SET_ONG))
                begin
                    ong_valid_reg[ch_sel] <= 1'b1;
                    ong_start_reg[ch_sel] <= cmd_reg.start_time;
                    ong_end_reg[ch_sel]   <= cmd_reg.end_time;
                end
                if (ch_ok && (cmd_reg.op == OP_CLR_ONG))
                    ong_valid_reg[ch_sel] <= 1'b0;
            end
            else if ((state_reg == S_OUT) && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= in_data;
        if (state_reg == S_APPLY)
            out_reg <= res;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/irt_cell.sv =====
// One slot of a channel chain: holds an interval, flags it against the command,
// ripples the first-hit flag and its payload, and shifts for insert or delete. Uses irt_pkg.
module irt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  irt_pkg::cell_cmd_t cmd,
    input  irt_pkg::shift_t   shift,
    input  logic              occ,
    input  logic              head,
    input  irt_pkg::slot_t    prev_data,
    input  irt_pkg::slot_t    next_data,
    input  logic              prev_ge,
    input  logic              prev_seen,
    input  irt_pkg::slot_t    prev_carry,
    output irt_pkg::slot_t    data,
    output logic              ge,
    output logic              seen,
    output irt_pkg::slot_t    carry
);
    import irt_pkg::*;

    slot_t data_reg;
    slot_t carry_reg;
    logic  hit_reg;
    logic  ge_reg;
    logic  seen_reg;
    logic  hit_next;

    always_comb
    begin
        case (cmd.op)
            OP_INSERT: hit_next = occ && touches(cmd.item.t_start, cmd.item.t_end,
                                                 data_reg.t_start, data_reg.t_end);
            OP_REMOVE: hit_next = occ && head;
            OP_DELETE: hit_next = occ && (data_reg.id == cmd.tid);
            default:   hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            ge_reg   <= 1'b0;
            seen_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= hit_next;
            ge_reg   <= !occ || (data_reg.t_start > cmd.item.t_start);
            seen_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            seen_reg <= hit_reg || prev_seen;
        end
    end

    // carry holds the payload of the earliest hit at or before this cell
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            carry_reg <= prev_seen ? prev_carry : data_reg;
        end
        if (shift.ins)
        begin
            if (prev_ge)
                data_reg <= prev_data;
            else if (ge_reg)
                data_reg <= cmd.item;
        end
        else if (shift.del && seen_reg)
        begin
            data_reg <= next_data;
        end
    end

    assign data  = data_reg;
    assign ge    = ge_reg;
    assign seen  = seen_reg;
    assign carry = carry_reg;

endmodule

// ===== design/irt_chain.sv =====
// Sorted chain of slots for one channel: decodes occupancy from the fill count
// and links the cells to their neighbors. Uses irt_pkg and irt_cell.
module irt_chain #(
    parameter int ENTRIES = 32,
    parameter int FILL_W  = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  irt_pkg::cell_cmd_t cmd,
    input  irt_pkg::shift_t    shift,
    input  logic [FILL_W-1:0]  fill,
    output logic               any_hit,
    output irt_pkg::slot_t     hit_slot
);
    import irt_pkg::*;

    slot_t data_w  [ENTRIES];
    slot_t carry_w [ENTRIES];
    logic  ge_w    [ENTRIES];
    logic  seen_w  [ENTRIES];

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            logic  occ;
            slot_t prev_d;
            slot_t next_d;
            slot_t prev_c;
            logic  prev_g;
            logic  prev_s;

            assign occ = fill > FILL_W'(i);

            if (i == 0)
            begin : g_head
                assign prev_d = data_w[0];
                assign prev_c = data_w[0];
                assign prev_g = 1'b0;
                assign prev_s = 1'b0;
            end
            else
            begin : g_body
                assign prev_d = data_w[i-1];
                assign prev_c = carry_w[i-1];
                assign prev_g = ge_w[i-1];
                assign prev_s = seen_w[i-1];
            end

            if (i == ENTRIES - 1)
            begin : g_tail
                assign next_d = data_w[i];
            end
            else
            begin : g_next
                assign next_d = data_w[i+1];
            end

            irt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .shift     (shift),
                .occ       (occ),
                .head      (i == 0),
                .prev_data (prev_d),
                .next_data (next_d),
                .prev_ge   (prev_g),
                .prev_seen (prev_s),
                .prev_carry(prev_c),
                .data      (data_w[i]),
                .ge        (ge_w[i]),
                .seen      (seen_w[i]),
                .carry     (carry_w[i])
            );
        end
    endgenerate

    assign any_hit  = seen_w[ENTRIES-1];
    assign hit_slot = carry_w[ENTRIES-1];

endmodule

// ===== sim/interval_reservation_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the interval reservation table: a predictor of the
// table compares every result word. Depends on irt_pkg and interval_reservation_table.
module interval_reservation_table_tb;
    import irt_pkg::*;

    localparam int NCH = 4;
    localparam int NENT = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    interval_reservation_table #(.CHANNELS(NCH), .ENTRIES(NENT)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [TW-1:0]  tbl_start [NCH][NENT];
    logic [TW-1:0]  tbl_end [NCH][NENT];
    logic [IDW-1:0] tbl_id [NCH][NENT];
    int             tbl_fill [NCH];
    logic           ong_valid [NCH];
    logic [TW-1:0]  ong_start [NCH];
    logic [TW-1:0]  ong_end [NCH];
    logic [IDW-1:0] id_counter;
    logic [IDW-1:0] last_id;

    out_t pending_results[$];
    int   errors = 0;
    bit   stall_long = 1'b0;

    function automatic bit overlaps(logic [TW-1:0] s, logic [TW-1:0] e,
                                    logic [TW-1:0] os, logic [TW-1:0] oe);
        return ((s >= os) && (s <= oe)) || ((e >= os) && (e <= oe)) ||
               ((s < os) && (e > oe));
    endfunction

    function automatic void drop_entry(int ch, int pos);
        for (int i = pos; i + 1 < tbl_fill[ch]; i++)
        begin
            tbl_start[ch][i] = tbl_start[ch][i+1];
            tbl_end[ch][i] = tbl_end[ch][i+1];
            tbl_id[ch][i] = tbl_id[ch][i+1];
        end
        tbl_fill[ch]--;
    endfunction

    function automatic out_t predict_table(in_t w);
        out_t r;
        int ch;
        int pos;
        bit hit;
        r = '0;
        ch = w.channel_index;
        hit = 1'b0;
        case (w.op)
            OP_INSERT:
            begin
                for (int i = 0; i < tbl_fill[ch]; i++)
                    if (overlaps(w.start_time, w.end_time, tbl_start[ch][i], tbl_end[ch][i]))
                        hit = 1'b1;
                if (ong_valid[ch] && overlaps(w.start_time, w.end_time,
                                              ong_start[ch], ong_end[ch]))
                    hit = 1'b1;
                if (hit)
                    r.status = ST_COLLIDE;
                else if (tbl_fill[ch] >= NENT)
                    r.status = ST_FULL;
                else
                begin
                    pos = tbl_fill[ch];
                    for (int i = tbl_fill[ch] - 1; i >= 0; i--)
                        if (tbl_start[ch][i] > w.start_time)
                            pos = i;
                    for (int i = tbl_fill[ch]; i > pos; i--)
                    begin
                        tbl_start[ch][i] = tbl_start[ch][i-1];
                        tbl_end[ch][i] = tbl_end[ch][i-1];
                        tbl_id[ch][i] = tbl_id[ch][i-1];
                    end
                    tbl_start[ch][pos] = w.start_time;
                    tbl_end[ch][pos] = w.end_time;
                    tbl_id[ch][pos] = id_counter;
                    tbl_fill[ch]++;
                    r = '{ST_OK, id_counter, w.start_time, w.end_time, w.channel_index};
                    last_id = id_counter;
                    id_counter = (id_counter == ID_MAX) ? ID_FIRST : id_counter + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (tbl_fill[ch] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r = '{ST_OK, tbl_id[ch][0], tbl_start[ch][0], tbl_end[ch][0],
                          w.channel_index};
                    drop_entry(ch, 0);
                end
            end
            OP_DELETE:
            begin
                r.status = ST_NOID;
                for (int c = 0; c < NCH && !hit; c++)
                    for (int i = 0; i < tbl_fill[c] && !hit; i++)
                        if (tbl_id[c][i] == w.target_id)
                        begin
                            r = '{ST_OK, w.target_id, tbl_start[c][i], tbl_end[c][i],
                                  CHW'(c)};
                            drop_entry(c, i);
                            hit = 1'b1;
                        end
            end
            OP_SET_ONG:
            begin
                ong_valid[ch] = 1'b1;
                ong_start[ch] = w.start_time;
                ong_end[ch] = w.end_time;
            end
            OP_CLR_ONG: ong_valid[ch] = 1'b0;
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // hold valid after acceptance when the next word follows at once
    task automatic send_word(in_t w);
        int gap;
        gap = stall_long ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_table(w));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // receiver: random back-pressure, compare each accepted word
    always @(posedge clk)
    begin
        out_t exp_w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    exp_w = pending_results.pop_front();
                    if (out_data.status !== exp_w.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_w.status,
                                 out_data.status);
                        errors++;
                    end
                    if (out_data.entry_id !== exp_w.entry_id)
                    begin
                        $display("%0t: entry_id exp %h got %h", $time, exp_w.entry_id,
                                 out_data.entry_id);
                        errors++;
                    end
                    if (out_data.entry_start !== exp_w.entry_start)
                    begin
                        $display("%0t: entry_start exp %h got %h", $time,
                                 exp_w.entry_start, out_data.entry_start);
                        errors++;
                    end
                    if (out_data.entry_end !== exp_w.entry_end)
                    begin
                        $display("%0t: entry_end exp %h got %h", $time, exp_w.entry_end,
                                 out_data.entry_end);
                        errors++;
                    end
                    if (out_data.entry_channel !== exp_w.entry_channel)
                    begin
                        $display("%0t: entry_channel exp %0d got %0d", $time,
                                 exp_w.entry_channel, out_data.entry_channel);
                        errors++;
                    end
                end
            end
            if (stall_long)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 29) == 0)
                out_ready <= 1'b0;
            else if ($urandom_range(0, 2) == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic in_t make_word(logic [OPW-1:0] op, int ch, logic [TW-1:0] s,
                                      logic [TW-1:0] e, logic [IDW-1:0] tid);
        in_t w;
        w.op = op;
        w.channel_index = CHW'(ch);
        w.start_time = s;
        w.end_time = e;
        w.target_id = tid;
        return w;
    endfunction

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom(), $urandom()});
    endfunction

    task automatic test_directed();
        logic [TW-1:0] tmax;
        tmax = {TW{1'b1}};
        send_word(make_word(OP_REMOVE, 0, 0, 0, 0));            // empty channel
        send_word(make_word(OP_DELETE, 0, 0, 0, 0));            // id 0 never matches
        send_word(make_word(OP_INSERT, 0, 100, 200, 0));
        send_word(make_word(OP_INSERT, 0, 200, 300, 0));        // shared endpoint
        send_word(make_word(OP_INSERT, 0, 50, 100, 0));
        send_word(make_word(OP_INSERT, 0, 10, 500, 0));         // strict containment
        send_word(make_word(OP_INSERT, 0, 10, 20, 0));
        send_word(make_word(OP_INSERT, 1, tmax, tmax, 0));
        send_word(make_word(OP_INSERT, 1, 0, 0, 0));
        send_word(make_word(OP_INSERT, 2, 900, 800, 0));        // reversed interval
        send_word(make_word(OP_INSERT, 2, 850, 850, 0));
        send_word(make_word(OP_SET_ONG, 3, 1000, 2000, 0));
        send_word(make_word(OP_INSERT, 3, 1500, 1600, 0));
        send_word(make_word(OP_SET_ONG, 3, 5, 6, 0));           // overwrite
        send_word(make_word(OP_INSERT, 3, 1500, 1600, 0));
        send_word(make_word(OP_CLR_ONG, 3, 0, 0, 0));
        send_word(make_word(OP_CLR_ONG, 3, 0, 0, 0));
        send_word(make_word(OP_INSERT, 3, 5, 6, 0));
        send_word(make_word(3'd5, 1, tmax, tmax, ID_MAX));      // unknown ops
        send_word(make_word(3'd7, 2, 1, 1, 1));
        send_word(make_word(OP_DELETE, 0, 0, 0, 24'd1));
        send_word(make_word(OP_DELETE, 0, 0, 0, ID_MAX));
        send_word(make_word(OP_REMOVE, 0, 0, 0, 0));
        send_word(make_word(OP_REMOVE, 1, 0, 0, 0));
    endtask

    // fill one channel to capacity, then hit the full answer
    task automatic test_full_channel();
        for (int i = 0; i <= NENT + 1; i++)
            send_word(make_word(OP_INSERT, 2, TW'(10000 + 10 * i), TW'(10005 + 10 * i), 0));
        send_word(make_word(OP_INSERT, 2, TW'(10000), TW'(10001), 0));
        for (int i = 0; i < NENT + 1; i++)
            send_word(make_word(OP_REMOVE, 2, 0, 0, 0));
    endtask

    task automatic test_drain_pause();
        wait_drained();
        stall_long = 1'b1;
        repeat (20) send_word(make_word(OP_INSERT, $urandom_range(0, 3),
                                        TW'($urandom_range(0, 4000)),
                                        TW'($urandom_range(0, 4000)), 0));
        wait_drained();
        stall_long = 1'b0;
    endtask

    task automatic test_random(int count);
        in_t w;
        logic [TW-1:0] s;
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            s = (k % 5 == 0) ? rand_time() : TW'($urandom_range(0, 20000));
            w = make_word(OP_INSERT, $urandom_range(0, 3), s,
                          s + TW'($urandom_range(0, 300)), IDW'($urandom()));
            if (k < 45)
                ;
            else if (k < 60)
                w.op = OP_REMOVE;
            else if (k < 78)
            begin
                w.op = OP_DELETE;
                w.target_id = ($urandom_range(0, 3) == 0) ? IDW'($urandom()) :
                              last_id - IDW'($urandom_range(0, 40));
            end
            else if (k < 86)
                w.op = OP_SET_ONG;
            else if (k < 93)
                w.op = OP_CLR_ONG;
            else if (k < 97)
                w.end_time = rand_time();
            else
                w.op = OPW'($urandom_range(5, 7));
            send_word(w);
        end
    endtask

    initial
    begin
        for (int c = 0; c < NCH; c++)
        begin
            tbl_fill[c] = 0;
            ong_valid[c] = 1'b0;
            ong_start[c] = '0;
            ong_end[c] = '0;
        end
        id_counter = ID_FIRST;
        last_id = ID_FIRST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_channel();
        test_drain_pause();
        test_random(600);
        wait_drained();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS interval_reservation_table");
        else
            $display("FAIL interval_reservation_table");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL interval_reservation_table");
        $finish;
    end
endmodule

// ===== sim.f =====
design/irt_pkg.sv
design/irt_cell.sv
design/irt_chain.sv
design/interval_reservation_table.sv
sim/interval_reservation_table_tb.sv
